[hdl/skip_successor_table_macros.svh]
// Assertion macros of the skip successor table RTL, included by sst_ctrl.
// Depends on nothing; files that check their own logic include this header.
`ifndef SKIP_SUCCESSOR_TABLE_MACROS_SVH
`define SKIP_SUCCESSOR_TABLE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SST_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SST_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/sst_pkg.sv]
// Shared widths, payload types and command codes of the skip successor table.
// No dependencies; every file but the macro header imports this package.
package sst_pkg;

	localparam int ID_W   = 10;
	localparam int SUCC_W = 11;
	localparam int CNT_W  = 10;
	localparam int IDX_W  = 10;

	// Command field code; the other value is a query.
	localparam logic CMD_FILTER = 1'b0;

	typedef logic [ID_W-1:0]   id_t;
	typedef logic [SUCC_W-1:0] succ_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [IDX_W-1:0]  idx_t;

endpackage

[hdl/sst_ifs.sv]
// Valid/ready channel interfaces for commands and responses.
// Depends on sst_pkg for the payload types.
interface sst_cmd_if import sst_pkg::*; ();
	logic valid;
	logic ready;
	logic command;
	id_t  item_id;

	modport source (output valid, output command, output item_id, input ready);
	modport sink (input valid, input command, input item_id, output ready);
endinterface

interface sst_rsp_if import sst_pkg::*; ();
	logic  valid;
	logic  ready;
	succ_t successor_id;
	logic  is_removed;
	cnt_t  removed_total;
	idx_t  last_index;

	modport source (output valid, output successor_id, output is_removed,
		output removed_total, output last_index, input ready);
	modport sink (input valid, input successor_id, input is_removed,
		input removed_total, input last_index, output ready);
endinterface

[hdl/sst_mem.sv]
// Successor table storage: one write port, one read port, registered read data.
// Depends on sst_pkg for the entry type.
module sst_mem import sst_pkg::*; #(
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  succ_t                    wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output succ_t                    rdata
);

	succ_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read data holds while no read is issued.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[hdl/sst_ctrl.sv]
// Command sequencer of the skip successor table: extent fill, redirect sweep,
// query reads and the response register. Depends on sst_pkg, sst_ifs, macros.
`include "skip_successor_table_macros.svh"

module sst_ctrl import sst_pkg::*; #(
	parameter int TABLE_DEPTH = 1024
) (
	input  logic                           clk,
	input  logic                           arst_n,
	sst_cmd_if.sink                        cmd_ch,
	sst_rsp_if.source                      rsp_ch,
	output logic                           mem_we,
	output logic [$clog2(TABLE_DEPTH)-1:0] mem_waddr,
	output succ_t                          mem_wdata,
	output logic                           mem_re,
	output logic [$clog2(TABLE_DEPTH)-1:0] mem_raddr,
	input  succ_t                          mem_rdata
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int EW = $clog2(TABLE_DEPTH + 1);
	localparam int CW = (EW > SUCC_W) ? EW : SUCC_W;

	typedef logic [CW-1:0] wide_t;

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_CHK_RD = 4'd1;
	localparam logic [3:0] ST_CHK_EV = 4'd2;
	localparam logic [3:0] ST_FILL   = 4'd3;
	localparam logic [3:0] ST_NXT_RD = 4'd4;
	localparam logic [3:0] ST_NXT_EV = 4'd5;
	localparam logic [3:0] ST_SWEEP  = 4'd6;
	localparam logic [3:0] ST_QRY_A  = 4'd7;
	localparam logic [3:0] ST_QRY_B  = 4'd8;
	localparam logic [3:0] ST_QRY_C  = 4'd9;

	logic [3:0]    state_q;
	id_t           id_q;
	logic [EW-1:0] extent_q;
	cnt_t          count_q;
	wide_t         k_q;
	succ_t         nxt_q;
	succ_t         succ_q;
	logic          rd_v_s1;
	logic [AW-1:0] rd_addr_s1;

	logic          rsp_valid_q;
	succ_t         rsp_succ_q;
	logic          rsp_removed_q;
	cnt_t          rsp_total_q;
	idx_t          rsp_last_q;

	wide_t         id_w, ext_w, in_id_w, idm1_w;
	logic [AW-1:0] id_addr, idm1_addr;
	logic          in_range, filt_ok, sweep_rd, sweep_hit, accept, rsp_load;
	succ_t         id_as_succ;

	assign id_w       = wide_t'(id_q);
	assign ext_w      = wide_t'(extent_q);
	assign in_id_w    = wide_t'(cmd_ch.item_id);
	assign idm1_w     = id_w - wide_t'(1);
	assign id_addr    = id_w[AW-1:0];
	assign idm1_addr  = idm1_w[AW-1:0];
	assign id_as_succ = SUCC_W'(id_q);
	// Entries at or past the extent are not stored; they read as id plus one.
	assign in_range   = id_w < ext_w;
	assign filt_ok    = (in_id_w != '0) && (in_id_w + wide_t'(1) <= wide_t'(TABLE_DEPTH));
	assign sweep_rd   = k_q < id_w;
	assign sweep_hit  = rd_v_s1 && (mem_rdata == id_as_succ);
	assign accept     = cmd_ch.valid && cmd_ch.ready;
	assign rsp_load   = (state_q == ST_QRY_C) && (!rsp_valid_q || rsp_ch.ready);

	assign cmd_ch.ready         = (state_q == ST_IDLE);
	assign rsp_ch.valid         = rsp_valid_q;
	assign rsp_ch.successor_id  = rsp_succ_q;
	assign rsp_ch.is_removed    = rsp_removed_q;
	assign rsp_ch.removed_total = rsp_total_q;
	assign rsp_ch.last_index    = rsp_last_q;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = k_q[AW-1:0];
		mem_wdata = SUCC_W'(k_q + wide_t'(1));
		mem_re    = 1'b0;
		mem_raddr = id_addr;
		unique case (state_q)
			ST_CHK_RD: begin
				mem_re    = 1'b1;
				mem_raddr = idm1_addr;
			end
			ST_FILL: begin
				mem_we = 1'b1;
			end
			ST_NXT_RD: begin
				mem_re = 1'b1;
			end
			ST_SWEEP: begin
				// Read entry k while the entry read in the previous cycle is rewritten.
				mem_re    = sweep_rd;
				mem_raddr = k_q[AW-1:0];
				mem_we    = sweep_hit;
				mem_waddr = rd_addr_s1;
				mem_wdata = nxt_q;
			end
			ST_QRY_A: begin
				mem_re = in_range;
			end
			ST_QRY_B: begin
				mem_re    = in_range && (id_q != '0);
				mem_raddr = idm1_addr;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			extent_q <= '0;
			count_q  <= '0;
			rd_v_s1  <= 1'b0;
		end else begin
			rd_v_s1 <= (state_q == ST_SWEEP) && sweep_rd;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (cmd_ch.command == CMD_FILTER && filt_ok) begin
							if (in_id_w < ext_w) begin
								state_q <= ST_CHK_RD;
							end else begin
								count_q <= count_q + CNT_W'(1);
								state_q <= ST_FILL;
							end
						end else begin
							state_q <= ST_QRY_A;
						end
					end
				end
				ST_CHK_RD: state_q <= ST_CHK_EV;
				ST_CHK_EV: begin
					// The id is already removed when its predecessor skips it.
					if (mem_rdata != id_as_succ) begin
						state_q <= ST_QRY_A;
					end else begin
						count_q <= count_q + CNT_W'(1);
						state_q <= ST_NXT_RD;
					end
				end
				ST_FILL: begin
					if (k_q == id_w) begin
						extent_q <= EW'(id_w + wide_t'(1));
						state_q  <= ST_NXT_RD;
					end
				end
				ST_NXT_RD: state_q <= ST_NXT_EV;
				ST_NXT_EV: state_q <= ST_SWEEP;
				ST_SWEEP: begin
					if (!sweep_rd && !rd_v_s1) begin
						state_q <= ST_QRY_A;
					end
				end
				ST_QRY_A: state_q <= ST_QRY_B;
				ST_QRY_B: state_q <= ST_QRY_C;
				ST_QRY_C: begin
					if (rsp_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			id_q <= cmd_ch.item_id;
			k_q  <= ext_w;
		end
		if (state_q == ST_FILL && k_q != id_w) begin
			k_q <= k_q + wide_t'(1);
		end
		if (state_q == ST_NXT_EV) begin
			nxt_q <= mem_rdata;
			k_q   <= '0;
		end
		if (state_q == ST_SWEEP && sweep_rd) begin
			k_q <= k_q + wide_t'(1);
		end
		rd_addr_s1 <= k_q[AW-1:0];
		if (state_q == ST_QRY_B) begin
			succ_q <= in_range ? mem_rdata : SUCC_W'(id_w + wide_t'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ch.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_succ_q    <= succ_q;
			rsp_removed_q <= (id_q != '0) && in_range && (mem_rdata != id_as_succ);
			rsp_total_q   <= count_q;
			rsp_last_q    <= (extent_q == '0) ? '0 : IDX_W'(ext_w - wide_t'(1));
		end
	end

	`SST_ASSERT_IMPL(a_idle_no_write, clk, arst_n, state_q == ST_IDLE, !mem_we, "table written while idle")
	`SST_ASSERT_IMPL(a_sweep_below_id, clk, arst_n, mem_we && state_q == ST_SWEEP, wide_t'(mem_waddr) < id_w, "sweep wrote at or above the filtered id")
	`SST_ASSERT_NEXT(a_extent_grows, clk, arst_n, 1'b1, extent_q >= $past(extent_q), "table extent shrank")
	`SST_ASSERT_IMPL(a_extent_bound, clk, arst_n, 1'b1, ext_w <= wide_t'(TABLE_DEPTH), "table extent beyond depth")
	`SST_ASSERT_NEXT(a_count_stable, clk, arst_n, state_q != ST_IDLE && state_q != ST_CHK_EV, $stable(count_q), "removed count changed mid command")

endmodule

[hdl/skip_successor_table.sv]
// Skip successor table: a table of next unfiltered ids kept in one RAM.
// cmd_ch carries beats of {command, item_id}; command 0 filters the id out,
// command 1 queries it. Every command beat yields exactly one rsp_ch beat
// with the successor, the removed flag, the removed count and the last index
// of the table, as seen after the command has taken effect.
// A query, or a filter that changes nothing (id zero, id past the depth, an
// id already removed), goes through the query read states to the response
// register. A filter that takes effect first fills the entries from the
// extent up to the id when it grows the extent, then reads the successor of
// the id and sweeps the entries below it. The sweep reads one entry in each
// cycle and rewrites the one before it, when that entry skips to the id,
// through the single read port and single write port of the table RAM.
// One command is worked at a time; cmd_ch.ready is high only when the
// sequencer is idle, and it stays high while a response waits on a stalled
// receiver. A finished response then waits in its state until rsp_ch frees.
// Reset clears the extent, the count and the control state; the RAM needs
// no clearing pass, since entries at or beyond the extent are never read.
// Depends on sst_pkg, sst_ifs, sst_mem and sst_ctrl.
module skip_successor_table import sst_pkg::*; #(
	parameter int TABLE_DEPTH = 1024
) (
	input logic       clk,
	input logic       arst_n,
	sst_cmd_if.sink   cmd_ch,
	sst_rsp_if.source rsp_ch
);

	localparam int AW = $clog2(TABLE_DEPTH);

	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	succ_t         mem_wdata;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;
	succ_t         mem_rdata;

	sst_ctrl #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_ch    (cmd_ch),
		.rsp_ch    (rsp_ch),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	sst_mem #(
		.DEPTH(TABLE_DEPTH)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule

[test/tb_skip_successor_table.sv]
// Testbench for skip_successor_table: random and directed filter/query beats, each
// response checked against an in-bench copy of the successor table.
// Depends on sst_pkg, sst_ifs and the skip_successor_table RTL.
module tb_skip_successor_table;
	import sst_pkg::*;

	localparam int   DEPTH          = 1024;
	localparam int   ID_MAX         = DEPTH - 1;
	localparam int   WATCHDOG_LIMIT = 20000;
	localparam int   DRAIN_CYCLES   = 64;
	localparam logic CMD_QUERY      = ~CMD_FILTER;

	typedef struct {
		succ_t successor_id;
		logic  is_removed;
		cnt_t  removed_total;
		idx_t  last_index;
	} rsp_beat_t;

	logic clk;
	logic arst_n;

	sst_cmd_if cmd_ch ();
	sst_rsp_if rsp_ch ();

	skip_successor_table #(.TABLE_DEPTH(DEPTH)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd_ch (cmd_ch),
		.rsp_ch (rsp_ch)
	);

	// Shadow copy of the table state.
	succ_t next_tab [DEPTH];
	succ_t tab_extent;
	cnt_t  removed_cnt;

	rsp_beat_t awaited_rsp [$];
	id_t       filtered_ids [$];

	int err_count;
	int cmd_gap_pct;
	int rsp_stall_pct;
	int rsp_hold_req;
	int n_filter_taken;
	int n_filter_noop;
	int n_query;
	int n_removed_hits;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 15);
		return $urandom_range(30, 120);
	endfunction

	function automatic succ_t next_of(input id_t id);
		if (succ_t'(id) >= tab_extent)
			return succ_t'(id) + 1'b1;
		return next_tab[id];
	endfunction

	function automatic logic removed_of(input id_t id);
		if (id == 0 || succ_t'(id) >= tab_extent)
			return 1'b0;
		return next_tab[id - 1'b1] != succ_t'(id);
	endfunction

	// Returns 1 when the filter changed the table.
	function automatic bit filter_id(input id_t id);
		succ_t nxt;
		if (id == 0 || int'(id) + 1 > DEPTH)
			return 1'b0;
		if (removed_of(id))
			return 1'b0;
		removed_cnt++;
		if (succ_t'(id) >= tab_extent) begin
			for (int k = int'(tab_extent); k <= int'(id); k++)
				next_tab[id_t'(k)] = succ_t'(k + 1);
			tab_extent = succ_t'(id) + 1'b1;
		end
		nxt = next_tab[id];
		for (int k = 0; k < int'(id); k++)
			if (next_tab[id_t'(k)] == succ_t'(id))
				next_tab[id_t'(k)] = nxt;
		return 1'b1;
	endfunction

	function automatic rsp_beat_t table_response(input logic cmd, input id_t id);
		rsp_beat_t r;
		if (cmd == CMD_FILTER) begin
			if (filter_id(id)) begin
				n_filter_taken++;
				filtered_ids.push_back(id);
			end else begin
				n_filter_noop++;
			end
		end else begin
			n_query++;
		end
		r.successor_id  = next_of(id);
		r.is_removed    = removed_of(id);
		r.removed_total = removed_cnt;
		r.last_index    = (tab_extent != 0) ? idx_t'(tab_extent - 1'b1) : '0;
		if (cmd == CMD_QUERY && r.is_removed)
			n_removed_hits++;
		return r;
	endfunction

	// Ids lean on small values and on ids already filtered, so chains build up.
	function automatic id_t pick_id();
		int  r;
		id_t id;
		r = $urandom_range(0, 99);
		if (r < 30 && filtered_ids.size() != 0) begin
			id = filtered_ids[$urandom_range(0, filtered_ids.size() - 1)];
			case ($urandom_range(0, 3))
				0: id = id - 1'b1;
				1: id = id + 1'b1;
				default: ;
			endcase
			return id;
		end
		if (r < 75)
			return id_t'($urandom_range(0, 63));
		if (r < 88)
			return id_t'($urandom_range(0, ID_MAX));
		return id_t'(int'(tab_extent) + $urandom_range(0, 2) - 1);
	endfunction

	task automatic idle_cmd(input int n);
		@(negedge clk);
		cmd_ch.valid   <= 1'b0;
		cmd_ch.command <= 1'($urandom_range(0, 1));
		cmd_ch.item_id <= id_t'($urandom_range(0, ID_MAX));
		repeat (n - 1) @(negedge clk);
	endtask

	task automatic send_cmd(input logic cmd, input id_t id);
		@(negedge clk);
		cmd_ch.valid   <= 1'b1;
		cmd_ch.command <= cmd;
		cmd_ch.item_id <= id;
		do @(posedge clk); while (cmd_ch.ready !== 1'b1);
		awaited_rsp.push_back(table_response(cmd, id));
		if ($urandom_range(0, 99) < cmd_gap_pct)
			idle_cmd(pick_gap());
	endtask

	task automatic wait_drained();
		while (awaited_rsp.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_directed();
		cmd_gap_pct   = 30;
		rsp_stall_pct = 20;
		send_cmd(CMD_QUERY, 0);
		send_cmd(CMD_QUERY, id_t'(ID_MAX));
		send_cmd(CMD_FILTER, 0);
		send_cmd(CMD_FILTER, 1);
		send_cmd(CMD_FILTER, 1);
		send_cmd(CMD_QUERY, 0);
		send_cmd(CMD_FILTER, 2);
		send_cmd(CMD_QUERY, 0);
		send_cmd(CMD_QUERY, 1);
		send_cmd(CMD_QUERY, 3);
		send_cmd(CMD_FILTER, 6);
		send_cmd(CMD_FILTER, 4);
		send_cmd(CMD_FILTER, 5);
		send_cmd(CMD_QUERY, 3);
		send_cmd(CMD_QUERY, 5);
		// Filtering 3 merges the run 1..2 with the run 4..6.
		send_cmd(CMD_FILTER, 3);
		send_cmd(CMD_QUERY, 0);
		send_cmd(CMD_FILTER, 682);
		send_cmd(CMD_QUERY, 341);
		send_cmd(CMD_QUERY, 681);
		send_cmd(CMD_QUERY, 682);
		send_cmd(CMD_QUERY, 683);
		send_cmd(CMD_QUERY, id_t'(ID_MAX));
		send_cmd(CMD_FILTER, 0);
		send_cmd(CMD_QUERY, 0);
	endtask

	task automatic test_random_mix(input int n_items, input int gap_pct, input int stall_pct);
		logic cmd;
		cmd_gap_pct   = gap_pct;
		rsp_stall_pct = stall_pct;
		repeat (n_items) begin
			cmd = ($urandom_range(0, 99) < 45) ? CMD_FILTER : CMD_QUERY;
			send_cmd(cmd, pick_id());
		end
	endtask

	// The receiver holds off long enough for the block to fill and stall its input.
	task automatic test_backpressure();
		cmd_gap_pct  = 0;
		rsp_hold_req = 600;
		repeat (12)
			send_cmd($urandom_range(0, 1) ? CMD_FILTER : CMD_QUERY,
				id_t'($urandom_range(0, 63)));
	endtask

	task automatic test_drain_pause();
		cmd_gap_pct   = 20;
		rsp_stall_pct = 30;
		repeat (4)
			send_cmd(CMD_FILTER, pick_id());
		idle_cmd(1);
		wait_drained();
		repeat (8)
			send_cmd(CMD_QUERY, pick_id());
	endtask

	task automatic test_top_id();
		cmd_gap_pct   = 10;
		rsp_stall_pct = 10;
		send_cmd(CMD_FILTER, id_t'(ID_MAX));
		send_cmd(CMD_QUERY, id_t'(ID_MAX));
		send_cmd(CMD_QUERY, id_t'(ID_MAX - 1));
		send_cmd(CMD_FILTER, id_t'(ID_MAX));
	endtask

	initial begin : rsp_sink
		int stall_left;
		stall_left   = 0;
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (rsp_hold_req > 0) begin
				stall_left   = rsp_hold_req;
				rsp_hold_req = 0;
			end else if (stall_left == 0 && $urandom_range(0, 99) < rsp_stall_pct) begin
				stall_left = pick_gap();
			end
			if (stall_left > 0) begin
				rsp_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	function automatic void check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			err_count++;
		end
	endfunction

	initial begin : rsp_check
		rsp_beat_t want;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
				if (awaited_rsp.size() == 0) begin
					$error("response beat with no command outstanding");
					err_count++;
				end else begin
					want = awaited_rsp.pop_front();
					check_field("successor_id", 32'(want.successor_id),
						32'(rsp_ch.successor_id));
					check_field("is_removed", 32'(want.is_removed),
						32'(rsp_ch.is_removed));
					check_field("removed_total", 32'(want.removed_total),
						32'(rsp_ch.removed_total));
					check_field("last_index", 32'(want.last_index),
						32'(rsp_ch.last_index));
				end
			end
		end
	end

	initial begin : watchdog
		int quiet_cycles;
		quiet_cycles = 0;
		@(posedge arst_n);
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$error("no beat moved for %0d cycles", WATCHDOG_LIMIT);
		$display("FAIL");
		$finish;
	end

	initial begin : main
		arst_n         = 1'b0;
		cmd_ch.valid   = 1'b0;
		cmd_ch.command = CMD_QUERY;
		cmd_ch.item_id = '0;
		tab_extent     = '0;
		removed_cnt    = '0;
		err_count      = 0;
		cmd_gap_pct    = 0;
		rsp_stall_pct  = 0;
		rsp_hold_req   = 0;
		n_filter_taken = 0;
		n_filter_noop  = 0;
		n_query        = 0;
		n_removed_hits = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_random_mix(220, 30, 30);
		test_backpressure();
		test_random_mix(60, 0, 0);
		test_drain_pause();
		test_random_mix(240, 40, 40);
		test_top_id();

		idle_cmd(1);
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d filters (%0d took effect, %0d left the table alone) and %0d queries,",
			n_filter_taken + n_filter_noop, n_filter_taken, n_filter_noop, n_query);
		$display("%0d queries hit removed ids; final extent %0d, removed count %0d.",
			n_removed_hits, tab_extent, removed_cnt);
		if (err_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
